FILE: rtl/dbi_pkg.sv
// Shared types and constants for the depth bucket insert block.
// Used by dbi_dist, dbi_store and depth_bucket_insert; no dependencies.
package dbi_pkg;

    // Default sizes, handed to the top level parameters
    localparam int DEF_BUCKET_COUNT  = 1024;
    localparam int DEF_PRIM_CAPACITY = 2048;

    // Fixed field widths of the ports
    localparam int COORD_W       = 24;
    localparam int PAGE_W        = 16;
    localparam int PRIM_SLOT_W   = 11;
    localparam int BUCKET_IDX_W  = 10;
    localparam int LINKED_TO_W   = 12;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 24;

    // Distance arithmetic: Q17.8 differences, Q.16 sums, Q.8 distance
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SUM_W      = 2 * DIFF_W;
    localparam int FAR_SHIFT  = 20;               // 4096.0 in Q.8 is 2^20
    localparam int RAD_W      = 2 * FAR_SHIFT;    // radicand below the far limit
    localparam int ROOT_W     = FAR_SHIFT;
    localparam int REM_W      = ROOT_W + 3;
    localparam int DIST_W     = FAR_SHIFT + 1;
    localparam int STEP_CNT_W = 5;
    localparam int SQ_TERMS   = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CAMERA_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAMERA_Y = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAMERA_Z = 2'd2;

    // Status from the store to the sequencer
    typedef struct packed {
        logic clearing;   // bucket head sweep after reset in progress
        logic full;       // primitive store has no free slot
    } t_store_stat;

endpackage

FILE: rtl/dbi_dist.sv
// Camera distance and bucket selection unit for the depth bucket insert block.
// Shared squarer, one-bit-per-cycle square root, scale multiply. Uses dbi_pkg.
module dbi_dist import dbi_pkg::*; #(
    parameter int  BUCKET_COUNT = DEF_BUCKET_COUNT,
    localparam int BKT_W        = $clog2(BUCKET_COUNT)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [COORD_W-1:0]  i_pos_x,
    input  logic [COORD_W-1:0]  i_pos_y,
    input  logic [COORD_W-1:0]  i_pos_z,
    input  logic [COORD_W-1:0]  i_cam_x,
    input  logic [COORD_W-1:0]  i_cam_y,
    input  logic [COORD_W-1:0]  i_cam_z,
    output logic                o_done,
    output logic [BKT_W-1:0]    o_bucket
);

    localparam int PROD_W = DIST_W + BKT_W;
    localparam logic [BKT_W-1:0] BKT_MAX = BKT_W'(BUCKET_COUNT - 1);

    typedef enum logic [2:0] {
        D_IDLE,
        D_SQ,
        D_PREP,
        D_ROOT,
        D_SCALE,
        D_BKT,
        D_OUT
    } t_dstate;

    t_dstate                  r_state;
    logic [STEP_CNT_W-1:0]    r_cnt;
    logic signed [DIFF_W-1:0] r_dx, r_dy, r_dz;
    logic [SUM_W-1:0]         r_prod;
    logic [SUM_W-1:0]         r_sum;
    logic [RAD_W-1:0]         r_rad;
    logic                     r_far;
    logic [REM_W-1:0]         r_rem;
    logic [ROOT_W-1:0]        r_root;
    logic [PROD_W-1:0]        r_sprod;
    logic [BKT_W-1:0]         r_bucket;

    logic signed [DIFF_W-1:0] w_op;
    logic signed [SUM_W-1:0]  w_sq;
    logic [REM_W-1:0]         w_rem_sh;
    logic [REM_W-1:0]         w_trial;
    logic [DIST_W-1:0]        w_dist;
    logic [PROD_W-1:0]        w_sprod;

    assign w_op = (r_cnt == STEP_CNT_W'(0)) ? r_dx :
                  (r_cnt == STEP_CNT_W'(1)) ? r_dy : r_dz;
    assign w_sq = w_op * w_op;

    // one restoring square root step: bring down two radicand bits
    assign w_rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign w_trial  = REM_W'({r_root, 2'b01});

    assign w_dist  = r_far ? DIST_W'(1) << FAR_SHIFT : DIST_W'(r_root);
    assign w_sprod = PROD_W'(BKT_MAX) * PROD_W'(w_dist);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_dx    <= $signed({i_pos_x[COORD_W-1], i_pos_x})
                                 - $signed({i_cam_x[COORD_W-1], i_cam_x});
                        r_dy    <= $signed({i_pos_y[COORD_W-1], i_pos_y})
                                 - $signed({i_cam_y[COORD_W-1], i_cam_y});
                        r_dz    <= $signed({i_pos_z[COORD_W-1], i_pos_z})
                                 - $signed({i_cam_z[COORD_W-1], i_cam_z});
                        r_sum   <= '0;
                        r_cnt   <= '0;
                        r_state <= D_SQ;
                    end
                end
                D_SQ: begin
                    // square one term per cycle, accumulate each square in the following cycle
                    if (r_cnt < STEP_CNT_W'(SQ_TERMS)) begin
                        r_prod <= SUM_W'(w_sq);
                    end
                    if (r_cnt != STEP_CNT_W'(0)) begin
                        r_sum <= r_sum + r_prod;
                    end
                    if (r_cnt == STEP_CNT_W'(SQ_TERMS)) begin
                        r_state <= D_PREP;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                D_PREP: begin
                    // sum at or above 2^40 means distance clamps at 4096.0
                    r_far   <= |r_sum[SUM_W-1:RAD_W];
                    r_rad   <= r_sum[RAD_W-1:0];
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= '0;
                    r_state <= (|r_sum[SUM_W-1:RAD_W]) ? D_SCALE : D_ROOT;
                end
                D_ROOT: begin
                    if (w_rem_sh >= w_trial) begin
                        r_rem  <= w_rem_sh - w_trial;
                        r_root <= {r_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= w_rem_sh;
                        r_root <= {r_root[ROOT_W-2:0], 1'b0};
                    end
                    r_rad <= {r_rad[RAD_W-3:0], 2'b00};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == STEP_CNT_W'(ROOT_W - 1)) begin
                        r_state <= D_SCALE;
                    end
                end
                D_SCALE: begin
                    r_sprod <= w_sprod;
                    r_state <= D_BKT;
                end
                D_BKT: begin
                    r_bucket <= BKT_MAX - r_sprod[FAR_SHIFT + BKT_W - 1:FAR_SHIFT];
                    r_state  <= D_OUT;
                end
                D_OUT: begin
                    r_state <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    assign o_done   = (r_state == D_OUT);
    assign o_bucket = r_bucket;

endmodule

FILE: rtl/dbi_store.sv
// Bucket head memory, link and page stores and slot count of the depth bucket
// insert block. Clears the bucket heads after reset. Uses dbi_pkg.
module dbi_store import dbi_pkg::*; #(
    parameter int  BUCKET_COUNT  = DEF_BUCKET_COUNT,
    parameter int  PRIM_CAPACITY = DEF_PRIM_CAPACITY,
    localparam int BKT_W         = $clog2(BUCKET_COUNT),
    localparam int SLOT_W        = (PRIM_CAPACITY > 1) ? $clog2(PRIM_CAPACITY) : 1,
    localparam int LINK_W        = $clog2(PRIM_CAPACITY + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_lookup,
    input  logic [BKT_W-1:0]   i_lookup_bucket,
    input  logic               i_commit,
    input  logic [BKT_W-1:0]   i_commit_bucket,
    input  logic [PAGE_W-1:0]  i_page,
    output logic [LINK_W-1:0]  o_head_q,
    output logic [SLOT_W-1:0]  o_slot,
    output t_store_stat        o_stat
);

    localparam logic [LINK_W-1:0] EMPTY_LINK = LINK_W'(PRIM_CAPACITY);
    localparam logic [BKT_W-1:0]  BKT_LAST   = BKT_W'(BUCKET_COUNT - 1);

    logic [LINK_W-1:0] mem_heads [BUCKET_COUNT];
    logic [LINK_W-1:0] mem_links [PRIM_CAPACITY];
    logic [PAGE_W-1:0] mem_pages [PRIM_CAPACITY];

    logic              r_clearing;
    logic [BKT_W-1:0]  r_clr_addr;
    logic [LINK_W-1:0] r_count;
    logic [LINK_W-1:0] r_head_q;
    logic [SLOT_W-1:0] w_slot;

    assign w_slot = r_count[SLOT_W-1:0];

    // sweep the heads to empty, one entry a cycle, and count committed slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_count    <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == BKT_LAST) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_commit) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // read and write of one item are sequenced apart, so no forwarding
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem_heads[r_clr_addr] <= EMPTY_LINK;
        end else if (i_commit) begin
            mem_heads[i_commit_bucket] <= LINK_W'(w_slot);
        end
        if (i_lookup) begin
            r_head_q <= mem_heads[i_lookup_bucket];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            mem_links[w_slot] <= r_head_q;
            mem_pages[w_slot] <= i_page;
        end
    end

    assign o_head_q        = r_head_q;
    assign o_slot          = w_slot;
    assign o_stat.clearing = r_clearing;
    assign o_stat.full     = (r_count == EMPTY_LINK);

endmodule

FILE: rtl/depth_bucket_insert.sv
// Depth bucket insert: one request at a time. Steps from accept to result valid:
// squaring, prep, 20 square root steps, scale, bucket, head read, head write,
// output register; the root steps are skipped when the distance clamps at 4096.0,
// and a request dropped on a full store goes straight to the output register. The
// next request is taken once the result is loaded. Synchronous active-low reset
// clears camera, count and control; the bucket head sweep then stalls the input.
module depth_bucket_insert import dbi_pkg::*; #(
    parameter int  BUCKET_COUNT  = DEF_BUCKET_COUNT,
    parameter int  PRIM_CAPACITY = DEF_PRIM_CAPACITY,
    localparam int BKT_W         = $clog2(BUCKET_COUNT),
    localparam int SLOT_W        = (PRIM_CAPACITY > 1) ? $clog2(PRIM_CAPACITY) : 1,
    localparam int LINK_W        = $clog2(PRIM_CAPACITY + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [COORD_W-1:0]       i_pos_x,
    input  logic [COORD_W-1:0]       i_pos_y,
    input  logic [COORD_W-1:0]       i_pos_z,
    input  logic [PAGE_W-1:0]        i_texture_page,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_accepted,
    output logic [PRIM_SLOT_W-1:0]   o_prim_slot,
    output logic [BUCKET_IDX_W-1:0]  o_bucket_index,
    output logic [LINKED_TO_W-1:0]   o_linked_to
);

    localparam logic [LINK_W-1:0] EMPTY_LINK = LINK_W'(PRIM_CAPACITY);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIST,
        S_READ,
        S_EMIT
    } t_state;

    t_state             r_state;
    logic [COORD_W-1:0] r_cam_x, r_cam_y, r_cam_z;
    logic [PAGE_W-1:0]  r_page;
    logic [BKT_W-1:0]   r_bucket;

    logic               r_res_accepted;
    logic [SLOT_W-1:0]  r_res_slot;
    logic [BKT_W-1:0]   r_res_bucket;
    logic [LINK_W-1:0]  r_res_link;

    logic               r_out_valid;
    logic               r_out_accepted;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [BKT_W-1:0]   r_out_bucket;
    logic [LINK_W-1:0]  r_out_link;

    logic               w_in_acc;
    logic               w_out_free;
    logic               w_out_load;
    logic               w_dist_start;
    logic               w_dist_done;
    logic [BKT_W-1:0]   w_dist_bucket;
    logic               w_lookup;
    logic               w_commit;
    logic [LINK_W-1:0]  w_head_q;
    logic [SLOT_W-1:0]  w_slot;
    t_store_stat        w_stat;
    logic [31:0]        w_slot_ext;
    logic [31:0]        w_bucket_ext;
    logic [31:0]        w_link_ext;

    assign o_in_stall   = (r_state != S_IDLE);
    assign w_in_acc     = i_in_valid && !o_in_stall;
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_out_load   = (r_state == S_EMIT) && w_out_free;
    assign w_dist_start = w_in_acc && !w_stat.full;
    assign w_lookup     = (r_state == S_DIST) && w_dist_done;
    assign w_commit     = (r_state == S_READ);

    dbi_dist #(
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_dist_start),
        .i_pos_x  (i_pos_x),
        .i_pos_y  (i_pos_y),
        .i_pos_z  (i_pos_z),
        .i_cam_x  (r_cam_x),
        .i_cam_y  (r_cam_y),
        .i_cam_z  (r_cam_z),
        .o_done   (w_dist_done),
        .o_bucket (w_dist_bucket)
    );

    dbi_store #(
        .BUCKET_COUNT  (BUCKET_COUNT),
        .PRIM_CAPACITY (PRIM_CAPACITY)
    ) u_store (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_lookup        (w_lookup),
        .i_lookup_bucket (w_dist_bucket),
        .i_commit        (w_commit),
        .i_commit_bucket (r_bucket),
        .i_page          (r_page),
        .o_head_q        (w_head_q),
        .o_slot          (w_slot),
        .o_stat          (w_stat)
    );

    // camera registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x <= '0;
            r_cam_y <= '0;
            r_cam_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CAMERA_X: r_cam_x <= i_cfg_wdata;
                CFG_CAMERA_Y: r_cam_y <= i_cfg_wdata;
                CFG_CAMERA_Z: r_cam_z <= i_cfg_wdata;
                default: begin
                    // unused index: drop the write
                end
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (!w_stat.clearing) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_page <= i_texture_page;
                        if (w_stat.full) begin
                            r_res_accepted <= 1'b0;
                            r_res_slot     <= '0;
                            r_res_bucket   <= '0;
                            r_res_link     <= '0;
                            r_state        <= S_EMIT;
                        end else begin
                            r_state <= S_DIST;
                        end
                    end
                end
                S_DIST: begin
                    if (w_dist_done) begin
                        r_bucket <= w_dist_bucket;
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    r_res_accepted <= 1'b1;
                    r_res_slot     <= w_slot;
                    r_res_bucket   <= r_bucket;
                    r_res_link     <= w_head_q;
                    r_state        <= S_EMIT;
                end
                S_EMIT: begin
                    // hold the result until the output register frees up
                    if (w_out_free) begin
                        r_out_accepted <= r_res_accepted;
                        r_out_slot     <= r_res_slot;
                        r_out_bucket   <= r_res_bucket;
                        r_out_link     <= r_res_link;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign w_slot_ext   = 32'(r_out_slot);
    assign w_bucket_ext = 32'(r_out_bucket);
    assign w_link_ext   = 32'(r_out_link);

    assign o_out_valid    = r_out_valid;
    assign o_accepted     = r_out_accepted;
    assign o_prim_slot    = w_slot_ext[PRIM_SLOT_W-1:0];
    assign o_bucket_index = w_bucket_ext[BUCKET_IDX_W-1:0];
    assign o_linked_to    = w_link_ext[LINKED_TO_W-1:0];

    a_stall_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_stat.clearing |-> o_in_stall
    ) else $error("request taken during bucket head sweep");

    a_dist_done_in_dist: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_dist_done |-> (r_state == S_DIST)
    ) else $error("distance result outside the distance wait");

    a_slot_advances: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (w_slot == SLOT_W'($past(w_slot) + 1'b1))
    ) else $error("slot count did not advance on insert");

    a_link_older: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_accepted) |->
            ((r_out_link == EMPTY_LINK) || (r_out_link < LINK_W'(r_out_slot)))
    ) else $error("new entry linked to itself or a later slot");

endmodule
